[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/u8u2_pkg.sv]
// ----------------------------------------------------------------------------
// u8u2_pkg
// Types and constants shared by the UTF-8 to UCS-2 decoder modules.
// ----------------------------------------------------------------------------
package u8u2_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned UnitW    = 16;
  localparam int unsigned PendW    = 3;
  localparam int unsigned MaxPend  = 5;

  // One input item as held in the input register.
  typedef struct packed {
    logic [ByteW-1:0] byte_req;
    logic             last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             unit_valid;
    logic             end_mark;
  } res_item_t;

endpackage

[rtl/u8u2_in_reg.sv]
// ----------------------------------------------------------------------------
// u8u2_in_reg
// Input register: captures one byte item and hands it to the decoder.
// ----------------------------------------------------------------------------
module u8u2_in_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] byte_req
  input  logic                   in_tlast,   // last
  input  logic                   down_ready,
  output logic                   adv,
  output u8u2_pkg::in_item_t     item
);

  logic               s1_v_r;
  u8u2_pkg::in_item_t s1_item_r;

  // The held item moves on whenever the output side has room for a result.
  assign adv       = s1_v_r && down_ready;
  assign in_tready = !s1_v_r || adv;
  assign item      = s1_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.byte_req <= in_tdata;
      s1_item_r.last     <= in_tlast;
    end
  end

endmodule

[rtl/u8u2_decode.sv]
// ----------------------------------------------------------------------------
// u8u2_decode
// Sequence state and per-byte decode logic; one byte is consumed per fire.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8u2_decode (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  u8u2_pkg::in_item_t     item,
  output logic                   push,
  output u8u2_pkg::res_item_t    res
);

  logic [u8u2_pkg::PendW-1:0] pend_r, pend_nxt;
  logic [u8u2_pkg::UnitW-1:0] part_r, part_nxt;
  logic                       big_r, big_nxt;
  logic                       bad_r, bad_nxt;
  logic                       stop_r, stop_nxt;
  logic                       have_unit;
  logic [u8u2_pkg::UnitW-1:0] unit;
  logic [u8u2_pkg::ByteW-1:0] b;
  logic                       cont_ok;
  logic [u8u2_pkg::UnitW-1:0] part_sh;
  logic                       big_sh;

  assign b       = item.byte_req;
  assign cont_ok = (b[7:6] == 2'b10);
  // Only the low 16 bits are kept; big marks a value that has passed 0xFFFF,
  // which can only grow from there.
  assign part_sh = {part_r[9:0], b[5:0]};
  assign big_sh  = big_r || (part_r[15:10] != 6'd0);

  always_comb begin
    pend_nxt  = pend_r;
    part_nxt  = part_r;
    big_nxt   = big_r;
    bad_nxt   = bad_r;
    stop_nxt  = stop_r;
    have_unit = 1'b0;
    unit      = '0;
    if (stop_r) begin
      // Everything up to the final byte is ignored.
    end else if (pend_r == '0) begin
      unique casez (b)
        8'b0???????: begin
          if (b == 8'h00) begin
            stop_nxt = 1'b1;
          end else begin
            have_unit = 1'b1;
            unit      = {8'h00, b};
          end
        end
        8'b110?????: begin
          pend_nxt = 3'd1; part_nxt = {11'd0, b[4:0]}; big_nxt = 1'b0; bad_nxt = 1'b0;
        end
        8'b1110????: begin
          pend_nxt = 3'd2; part_nxt = {12'd0, b[3:0]}; big_nxt = 1'b0; bad_nxt = 1'b0;
        end
        8'b11110???: begin
          pend_nxt = 3'd3; part_nxt = {13'd0, b[2:0]}; big_nxt = 1'b0; bad_nxt = 1'b0;
        end
        8'b111110??: begin
          pend_nxt = 3'd4; part_nxt = {14'd0, b[1:0]}; big_nxt = 1'b0; bad_nxt = 1'b0;
        end
        8'b1111110?: begin
          pend_nxt = 3'd5; part_nxt = {15'd0, b[0]}; big_nxt = 1'b0; bad_nxt = 1'b0;
        end
        default: begin
          // Stray continuation byte or 0xFE/0xFF: skipped alone.
        end
      endcase
    end else begin
      if (!cont_ok) begin
        bad_nxt = 1'b1;
      end else if (!bad_r) begin
        part_nxt = part_sh;
        big_nxt  = big_sh;
      end
      pend_nxt = pend_r - 3'd1;
      if (pend_r == 3'd1) begin
        // Surrogate range is 0xD800..0xDFFF.
        if (!bad_nxt && !big_nxt && (part_nxt[15:11] != 5'b11011)) begin
          have_unit = 1'b1;
          unit      = part_nxt;
        end
        part_nxt = '0;
        big_nxt  = 1'b0;
        bad_nxt  = 1'b0;
      end
    end
    if (item.last) begin
      pend_nxt = '0;
      part_nxt = '0;
      big_nxt  = 1'b0;
      bad_nxt  = 1'b0;
      stop_nxt = 1'b0;
    end
  end

  assign push           = fire && (have_unit || item.last);
  assign res.code_unit  = unit;
  assign res.unit_valid = have_unit;
  assign res.end_mark   = item.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      part_r <= '0;
      big_r  <= 1'b0;
      bad_r  <= 1'b0;
      stop_r <= 1'b0;
    end else if (fire) begin
      pend_r <= pend_nxt;
      part_r <= part_nxt;
      big_r  <= big_nxt;
      bad_r  <= bad_nxt;
      stop_r <= stop_nxt;
    end
  end

  `ASSERT_ALWAYS(a_pend_max, pend_r <= 3'(u8u2_pkg::MaxPend), "pending count above five")
  `ASSERT_ALWAYS(a_stop_idle, !stop_r || (pend_r == '0), "stopped with a sequence open")
  `ASSERT_NEXT(a_last_clears, fire && item.last, pend_r == '0 && !stop_r && !bad_r,
               "final byte did not clear the sequence state")

endmodule

[rtl/u8u2_out_reg.sv]
// ----------------------------------------------------------------------------
// u8u2_out_reg
// Result register with a skid entry, so the decoder never waits on out_tready
// combinationally.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8u2_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  u8u2_pkg::res_item_t    res,
  output logic                   can_push,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [15:0]            out_tdata,  // [15:0] code_unit
  output logic                   out_tuser,  // unit_valid
  output logic                   out_tlast   // end_mark
);

  logic                main_v_r;
  logic                skid_v_r;
  u8u2_pkg::res_item_t main_r;
  u8u2_pkg::res_item_t skid_r;
  logic                main_free;

  assign main_free  = !main_v_r || out_tready;
  assign can_push   = !skid_v_r;
  assign out_tvalid = main_v_r;
  assign out_tdata  = main_r.code_unit;
  assign out_tuser  = main_r.unit_valid;
  assign out_tlast  = main_r.end_mark;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (main_free) begin
      main_v_r <= skid_v_r || push;
      skid_v_r <= skid_v_r && push;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_v_r) begin
        main_r <= skid_r;
        skid_r <= res;
      end else begin
        main_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  `ASSERT_ALWAYS(a_no_overflow, !(push && skid_v_r), "result pushed into a full buffer")
  `ASSERT_ALWAYS(a_skid_order, !skid_v_r || main_v_r, "skid entry held ahead of main entry")

endmodule

[rtl/utf8_to_ucs2_decoder_top.sv]
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_top
// UTF-8 byte stream to UCS-2 code unit decoder.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one UTF-8 byte per item in in_tdata, with in_tlast
//   high on the final byte of a buffer. The out_ channel carries results:
//   out_tdata is the UCS-2 code unit, out_tuser is high when it holds a
//   decoded character, and out_tlast marks the end of the converted string.
//   Bytes that finish no character and are not final yield no result item.
//   An accepted byte waits in the input register and is decoded from there
//   once the result register has room; its result is then registered. One
//   byte is taken every cycle while the skid entry is empty, through the
//   single registered decode pass between the two registers.
//   The result register has one skid entry. While out_tready stays low,
//   bytes that give no result keep flowing until a second result fills the
//   skid entry; the decoder then stops, and in_tready stays low while a byte
//   waits in the input register.
//   Reset (rst_n low, synchronous) empties both registers and clears the
//   sequence state, as does the final byte of each buffer.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_req
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] code_unit
  output logic        out_tuser,  // unit_valid
  output logic        out_tlast   // end_mark
);

  logic                down_ready;
  logic                adv;
  logic                push;
  u8u2_pkg::in_item_t  item;
  u8u2_pkg::res_item_t res;

  u8u2_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .down_ready (down_ready),
    .adv        (adv),
    .item       (item)
  );

  u8u2_decode u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .item  (item),
    .push  (push),
    .res   (res)
  );

  u8u2_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .res        (res),
    .can_push   (down_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
